/* rtl/core/bads_pkg.sv */
package bads_pkg;

  // data and register widths fixed by the stream and register map
  localparam int PIX_W     = 8;
  localparam int CFG_DIM_W = 11;
  localparam int CFG_LG_W  = 2;
  localparam int CFG_IDX_W = 2;

  // defaults for the top level parameters
  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int MAX_LOG2_FACTOR_DEF = 3;

  // source rows per frame never exceed this
  localparam int MAX_HEIGHT = 1024;

  // register reset values
  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = CFG_DIM_W'(480);
  localparam logic [CFG_LG_W-1:0]  LOG2_FACTOR_RST  = CFG_LG_W'(1);

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_LOG2_FACTOR  = 2'd2
  } cfg_reg_t;

endpackage

/* rtl/core/bads_ram.sv */
module bads_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port, read returns old data on collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/box_average_downscale_core.sv */
// a result reaches the master side through stage one and the output register
// throughput: one pixel per clock unless the output stalls, set by the line store's
//   single read-modify-write (write-back forwarded to the next read of that column)
// reset: counters cleared, registers to 640 x 480 and factor 2, output empty;
//   the line store is not cleared, the first pixel of each block overwrites its entry
module box_average_downscale_core #(
  parameter int MAX_WIDTH       = bads_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LOG2_FACTOR = bads_pkg::MAX_LOG2_FACTOR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bads_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bads_pkg::CFG_DIM_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bads_pkg::PIX_W-1:0]     s_tdata,   // pixel_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bads_pkg::PIX_W-1:0]     m_tdata,   // pixel_out
  output logic                           m_tlast    // frame_done
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
  localparam int WV_W   = (bads_pkg::CFG_DIM_W > WMAX_W) ? bads_pkg::CFG_DIM_W : WMAX_W;
  localparam int ROW_W  = $clog2(bads_pkg::MAX_HEIGHT);
  localparam int H_W    = bads_pkg::CFG_DIM_W;
  localparam int F_W    = MAX_LOG2_FACTOR;
  localparam int SUM_W  = 2 * MAX_LOG2_FACTOR + bads_pkg::PIX_W;
  localparam int LG_W   = bads_pkg::CFG_LG_W;

  typedef struct packed {
    logic                       first;
    logic                       emit;
    logic                       last;
    logic [bads_pkg::PIX_W-1:0] pix;
    logic [COL_W-1:0]           addr;
  } stage_t;

  // configuration registers
  logic [bads_pkg::CFG_DIM_W-1:0] frame_width;
  logic [bads_pkg::CFG_DIM_W-1:0] frame_height;
  logic [LG_W-1:0]                log2_factor;

  // raster cursor
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic [F_W-1:0]   rib, rib_next;

  // effective geometry
  logic [WV_W-1:0] fw_ext, w, out_cols;
  logic [H_W-1:0]  h, out_rows;
  logic [LG_W-1:0] lg;
  logic [F_W-1:0]  fmask;

  // cursor decode
  logic [COL_W-1:0] ocol;
  logic [ROW_W-1:0] orow;
  logic [F_W-1:0]   cib, rib_m;
  logic             in_range;
  logic [WV_W-1:0]  col_inc;
  logic [H_W-1:0]   row_inc;

  // pipeline
  logic             accept, advance;
  logic             s1_valid;
  stage_t           s1, s0;
  logic [SUM_W-1:0] rd_data, src, sum;
  logic             wr_en;
  logic             fwd_valid;
  logic [COL_W-1:0] fwd_addr;
  logic [SUM_W-1:0] fwd_data;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bads_pkg::FRAME_WIDTH_RST;
      frame_height <= bads_pkg::FRAME_HEIGHT_RST;
      log2_factor  <= bads_pkg::LOG2_FACTOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bads_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bads_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        bads_pkg::REG_LOG2_FACTOR:  log2_factor  <= cfg_data[LG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry and factor
  always_comb begin
    fw_ext = WV_W'(frame_width);
    if (fw_ext == '0) begin
      w = WV_W'(1);
    end else if (fw_ext > WV_W'(MAX_WIDTH)) begin
      w = WV_W'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    if (frame_height == '0) begin
      h = H_W'(1);
    end else if (frame_height > H_W'(bads_pkg::MAX_HEIGHT)) begin
      h = H_W'(bads_pkg::MAX_HEIGHT);
    end else begin
      h = frame_height;
    end
    if (int'(log2_factor) > MAX_LOG2_FACTOR) begin
      lg = LG_W'(MAX_LOG2_FACTOR);
    end else begin
      lg = log2_factor;
    end
    fmask    = ~({F_W{1'b1}} << lg);
    out_cols = w >> lg;
    out_rows = h >> lg;
  end

  // decode the cursor for the pixel on the slave side
  always_comb begin
    ocol     = col >> lg;
    orow     = row >> lg;
    cib      = F_W'(col) & fmask;
    rib_m    = rib & fmask;
    in_range = (WV_W'(ocol) < out_cols) && (H_W'(orow) < out_rows);
    s0.first = (rib_m == '0) && (cib == '0);
    s0.emit  = (rib_m == fmask) && (cib == fmask);
    s0.last  = (WV_W'(ocol) == out_cols - WV_W'(1)) && (H_W'(orow) == out_rows - H_W'(1));
    s0.pix   = s_tdata;
    s0.addr  = ocol;
  end

  // cursor advance
  always_comb begin
    col_inc  = WV_W'(col) + WV_W'(1);
    row_inc  = H_W'(row) + H_W'(1);
    col_next = col_inc[COL_W-1:0];
    row_next = row;
    rib_next = rib;
    if (col_inc >= w) begin
      col_next = '0;
      row_next = row_inc[ROW_W-1:0];
      rib_next = (rib_m + F_W'(1)) & fmask;
      if (row_inc >= h) begin
        row_next = '0;
        rib_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      rib <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      rib <= rib_next;
    end
  end

  // stage one holds while its result cannot enter the output register
  assign advance  = !s1_valid || !s1.emit || !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s0;
    end
  end

  // line store of partial block sums, one per output column
  bads_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1.addr),
    .wr_data (sum),
    .rd_en   (accept && in_range),
    .rd_addr (ocol),
    .rd_data (rd_data)
  );

  // accumulate, taking the last write-back when it hit the same column
  always_comb begin
    if (fwd_valid && (fwd_addr == s1.addr)) begin
      src = fwd_data;
    end else begin
      src = rd_data;
    end
    if (s1.first) begin
      sum = SUM_W'(s1.pix);
    end else begin
      sum = src + SUM_W'(s1.pix);
    end
  end

  assign wr_en = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1.addr;
      fwd_data <= sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (wr_en && s1.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1.emit) begin
      m_tdata <= bads_pkg::PIX_W'(sum >> {lg, 1'b0});
      m_tlast <= s1.last;
    end
  end

endmodule

/* rtl/core/bads_checker.sv */
module bads_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bads_pkg::PIX_W-1:0] m_tdata,
  input logic                       m_tlast
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // output is empty right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");

  // the slave side never stalls while the output register is empty
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a new result follows its input via stage one
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching input transaction");

endmodule

bind box_average_downscale_core bads_checker u_bads_checker (.*);
